// ----- rtl/rbba_pkg.sv -----
// ---------------------------------------------------------------------------
// rbba_pkg: shared constants and types
// Sizes of the region table and the usage bitmap, result codes, and the
// write request carried to the bitmap memory.
// ---------------------------------------------------------------------------
package rbba_pkg;

    localparam int MAX_REGIONS      = 8;
    localparam int BYTES_PER_REGION = 1024;

    localparam int REG_IDX_W  = $clog2(MAX_REGIONS);
    localparam int REG_CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int BYTE_IDX_W = $clog2(BYTES_PER_REGION);
    localparam int BYTES_W    = $clog2(BYTES_PER_REGION + 1);
    localparam int MEM_AW     = REG_IDX_W + BYTE_IDX_W;

    localparam int ADDR_W   = 48;
    localparam int CHUNK_SH = 17;
    localparam int BLOCK_SH = 14;
    localparam int FREE_W   = BYTES_W + CHUNK_SH;
    localparam int TOTAL_W  = 31;
    localparam int BSUM_W   = TOTAL_W - CHUNK_SH;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_TOO_SMALL = 3'd1;
    localparam status_t ST_SHRINK    = 3'd2;
    localparam status_t ST_NO_REGION = 3'd3;
    localparam status_t ST_FULL      = 3'd4;

    typedef logic [1:0] kind_t;
    localparam kind_t K_ADD   = 2'd0;
    localparam kind_t K_ALLOC = 2'd1;
    localparam kind_t K_MARK  = 2'd2;
    localparam kind_t K_CLEAR = 2'd3;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [7:0]        wdata;
    } mem_wr_t;

endpackage

// ----- rtl/rbba_ram.sv -----
// ---------------------------------------------------------------------------
// rbba_ram: usage bitmap memory
// One byte per 128 KiB chunk, one write port and one read port with a
// registered read.
// ---------------------------------------------------------------------------
module rbba_ram (
    input  logic                        clk,
    input  rbba_pkg::mem_wr_t           wr,
    input  logic [rbba_pkg::MEM_AW-1:0] raddr,
    output logic [7:0]                  rdata
);

    logic [7:0] mem [2**rbba_pkg::MEM_AW];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr] <= wr.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/region_bitmap_block_allocator.sv -----
// ---------------------------------------------------------------------------
// region_bitmap_block_allocator: 16 KiB block allocator over bitmap regions
// Keeps up to eight regions, each with one usage byte per 128 KiB chunk
// (MSB is the first block), and serves add, allocate, mark and clear
// requests, each answered by one result beat with the byte totals.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: kind; tdata: offset, length
//  m_axis    out        tdata: status, address, total_bytes, free_bytes
//
// One request is worked at a time. A clear passes through the summing
// state, over an emptied table, and the done state before it reaches the
// result register. An add that creates or grows a region sweeps the new
// bitmap bytes, one per cycle, followed by a rescan when a region grows.
// Allocate and mark walk the region table one entry a cycle and then
// read-modify-write one bitmap byte; a rescan reads each bitmap byte in
// S_RSRD and checks it in S_RSCK. Every request ends with a pass that
// sums the region table and a done state that loads the result register.
// Reset clears the region count and the control state; the bitmap memory
// needs no clearing since every byte is written before it is read. The
// result waits in an output register while the sink stalls, and a new
// request is taken only once the previous one has reached that register.
module region_bitmap_block_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [1:0]    s_axis_tuser,   // kind
    input  logic [95:0]   s_axis_tdata,   // offset[47:0], length[95:48]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [119:0]  m_axis_tdata    // status[2:0], address[50:3],
                                          // total_bytes[81:51], free_bytes[112:82]
);

    localparam int AW = rbba_pkg::ADDR_W;
    localparam int RI = rbba_pkg::REG_IDX_W;
    localparam int RC = rbba_pkg::REG_CNT_W;
    localparam int BI = rbba_pkg::BYTE_IDX_W;
    localparam int BW = rbba_pkg::BYTES_W;
    localparam int FW = rbba_pkg::FREE_W;
    localparam int CS = rbba_pkg::CHUNK_SH;
    localparam int KS = rbba_pkg::BLOCK_SH;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_ADD    = 12'b000000000010,
        S_NEWCLR = 12'b000000000100,
        S_EXTCLR = 12'b000000001000,
        S_ALLOC  = 12'b000000010000,
        S_MSRCH  = 12'b000000100000,
        S_MRD    = 12'b000001000000,
        S_MCK    = 12'b000010000000,
        S_RSRD   = 12'b000100000000,
        S_RSCK   = 12'b001000000000,
        S_SUM    = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } state_t;

    // Region table, read and written at the walking index only.
    logic [AW-1:0] rg_start [rbba_pkg::MAX_REGIONS];
    logic [BW-1:0] rg_bytes [rbba_pkg::MAX_REGIONS];
    logic [FW-1:0] rg_free  [rbba_pkg::MAX_REGIONS];
    logic          rg_full  [rbba_pkg::MAX_REGIONS];
    logic [AW-1:0] rg_ff    [rbba_pkg::MAX_REGIONS];

    state_t                   state_reg, state_next;
    logic [RC-1:0]            count_reg, count_next;
    logic [RC-1:0]            r_reg, r_next;
    rbba_pkg::kind_t          op_reg, op_next;
    logic [AW-1:0]            off_reg, off_next;
    logic [AW-1:0]            start_reg, start_next;
    logic [BW-1:0]            nb_reg, nb_next;
    logic [BW-1:0]            j_reg, j_next;
    logic [BW-1:0]            scan_reg, scan_next;
    logic [BI-1:0]            byte_reg, byte_next;
    logic [2:0]               bit_reg, bit_next;
    rbba_pkg::status_t        status_reg, status_next;
    logic [AW-1:0]            addr_reg, addr_next;
    logic [rbba_pkg::BSUM_W-1:0] tsum_reg, tsum_next;
    logic [rbba_pkg::TOTAL_W-1:0] fsum_reg, fsum_next;
    logic                     out_valid_reg, out_valid_next;
    logic [119:0]             out_data_reg, out_data_next;

    // Table update at the walking index.
    logic          tw_we;
    logic [AW-1:0] tw_start, tw_ff;
    logic [BW-1:0] tw_bytes;
    logic [FW-1:0] tw_free;
    logic          tw_full;

    rbba_pkg::mem_wr_t  mem_wr;
    logic [rbba_pkg::MEM_AW-1:0] mem_raddr;
    logic [7:0]         mem_rdata;

    logic [RI-1:0] cur;
    logic [AW-1:0] cur_start, cur_ff;
    logic [BW-1:0] cur_bytes;
    logic [FW-1:0] cur_free;
    logic          cur_full;

    // Add request decode, straight from the input beat.
    logic [AW-1:0] in_off, in_len;
    logic [AW:0]   a_start, a_sum, a_end, a_span;
    logic [AW-CS:0] a_nb;

    // Mark and rescan helpers.
    logic [AW:0]   reg_end;
    logic [AW-1:0] rel;
    logic [7:0]    mask;
    logic [FW-1:0] new_free;
    logic          new_full;
    logic [AW-1:0] new_ff, fr;
    logic [2:0]    zpos;

    function automatic logic [2:0] first_zero(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!b[k])
            begin
                n = 3'(7 - k);
                break;
            end
        end
        return n;
    endfunction

    assign cur       = r_reg[RI-1:0];
    assign cur_start = rg_start[cur];
    assign cur_ff    = rg_ff[cur];
    assign cur_bytes = rg_bytes[cur];
    assign cur_free  = rg_free[cur];
    assign cur_full  = rg_full[cur];

    assign in_off  = s_axis_tdata[47:0];
    assign in_len  = s_axis_tdata[95:48];
    assign a_start = {1'b0, in_off[AW-1:CS], {CS{1'b0}}} + (AW+1)'(1 << CS);
    assign a_sum   = {1'b0, in_off} + {1'b0, in_len};
    assign a_end   = a_sum[AW] ? {1'b1, {AW{1'b0}}} : {1'b0, a_sum[AW-1:CS], {CS{1'b0}}};
    assign a_span  = a_end - a_start;
    assign a_nb    = a_span[AW:CS];

    assign reg_end  = {1'b0, cur_start} + (AW+1)'({cur_bytes, {CS{1'b0}}});
    assign rel      = off_reg - cur_start;
    assign mask     = 8'h80 >> bit_reg;
    assign new_free = (cur_free >= FW'(1 << KS)) ? cur_free - FW'(1 << KS) : '0;
    assign new_full = cur_full || (new_free == '0);
    assign new_ff   = (new_free == '0) ? '0 : cur_ff;
    assign fr       = new_ff - cur_start;
    assign zpos     = first_zero(mem_rdata);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        r_next         = r_reg;
        op_next        = op_reg;
        off_next       = off_reg;
        start_next     = start_reg;
        nb_next        = nb_reg;
        j_next         = j_reg;
        scan_next      = scan_reg;
        byte_next      = byte_reg;
        bit_next       = bit_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        tsum_next      = tsum_reg;
        fsum_next      = fsum_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        tw_we    = 1'b0;
        tw_start = cur_start;
        tw_bytes = cur_bytes;
        tw_free  = cur_free;
        tw_full  = cur_full;
        tw_ff    = cur_ff;
        mem_wr   = '0;
        mem_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next     = s_axis_tuser;
                    off_next    = in_off;
                    start_next  = a_start[AW-1:0];
                    nb_next     = a_nb[BW-1:0];
                    status_next = rbba_pkg::ST_OK;
                    addr_next   = '0;
                    r_next      = '0;
                    tsum_next   = '0;
                    fsum_next   = '0;
                    unique case (s_axis_tuser)
                        rbba_pkg::K_ADD:
                        begin
                            priority if (a_end <= a_start)
                            begin
                                status_next = rbba_pkg::ST_TOO_SMALL;
                                state_next  = S_SUM;
                            end
                            else if (a_nb > (AW-CS+1)'(rbba_pkg::BYTES_PER_REGION))
                            begin
                                status_next = rbba_pkg::ST_FULL;
                                state_next  = S_SUM;
                            end
                            else
                            begin
                                state_next = S_ADD;
                            end
                        end
                        rbba_pkg::K_ALLOC: state_next = S_ALLOC;
                        rbba_pkg::K_MARK:  state_next = S_MSRCH;
                        rbba_pkg::K_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_SUM;
                        end
                        default: state_next = S_SUM;
                    endcase
                end
            end

            S_ADD:
            begin
                if (r_reg < count_reg)
                begin
                    if (cur_start == start_reg)
                    begin
                        priority if (cur_bytes == nb_reg)
                        begin
                            r_next = '0;
                            state_next = S_SUM;
                        end
                        else if (cur_bytes > nb_reg)
                        begin
                            status_next = rbba_pkg::ST_SHRINK;
                            r_next = '0;
                            state_next = S_SUM;
                        end
                        else
                        begin
                            j_next = cur_bytes;
                            state_next = S_EXTCLR;
                        end
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
                else if (count_reg >= RC'(rbba_pkg::MAX_REGIONS))
                begin
                    status_next = rbba_pkg::ST_FULL;
                    r_next = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    tw_we    = 1'b1;
                    tw_start = start_reg;
                    tw_ff    = start_reg;
                    tw_bytes = nb_reg;
                    tw_free  = {nb_reg, {CS{1'b0}}};
                    tw_full  = 1'b0;
                    count_next = count_reg + 1'b1;
                    j_next = '0;
                    state_next = S_NEWCLR;
                end
            end

            S_NEWCLR:
            begin
                mem_wr.we    = 1'b1;
                mem_wr.waddr = {cur, j_reg[BI-1:0]};
                mem_wr.wdata = 8'h00;
                j_next = j_reg + 1'b1;
                if (j_reg == nb_reg - 1'b1)
                begin
                    r_next = '0;
                    state_next = S_SUM;
                end
            end

            S_EXTCLR:
            begin
                // The first new chunk is marked fully used, the rest free.
                mem_wr.we    = 1'b1;
                mem_wr.waddr = {cur, j_reg[BI-1:0]};
                mem_wr.wdata = (j_reg == cur_bytes) ? 8'hff : 8'h00;
                j_next = j_reg + 1'b1;
                if (j_reg == nb_reg - 1'b1)
                begin
                    tw_we    = 1'b1;
                    tw_free  = FW'({nb_reg - cur_bytes, {CS{1'b0}}})
                             + cur_free - FW'(1 << CS);
                    tw_bytes = nb_reg;
                    tw_full  = 1'b0;
                    tw_ff    = start_reg;
                    scan_next  = '0;
                    state_next = S_RSRD;
                end
            end

            S_ALLOC:
            begin
                if (r_reg < count_reg)
                begin
                    if (!cur_full)
                    begin
                        addr_next = cur_ff;
                        off_next  = cur_ff;
                        r_next    = '0;
                        state_next = S_MSRCH;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
                else
                begin
                    r_next = '0;
                    state_next = S_SUM;
                end
            end

            S_MSRCH:
            begin
                if (r_reg < count_reg)
                begin
                    if (off_reg >= cur_start && {1'b0, off_reg} < reg_end)
                    begin
                        byte_next  = rel[CS+BI-1:CS];
                        bit_next   = rel[CS-1:KS];
                        state_next = S_MRD;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
                else
                begin
                    if (op_reg == rbba_pkg::K_MARK)
                    begin
                        status_next = rbba_pkg::ST_NO_REGION;
                    end
                    r_next = '0;
                    state_next = S_SUM;
                end
            end

            S_MRD:
            begin
                mem_raddr  = {cur, byte_reg};
                state_next = S_MCK;
            end

            S_MCK:
            begin
                if ((mem_rdata & mask) == 8'h00)
                begin
                    mem_wr.we    = 1'b1;
                    mem_wr.waddr = {cur, byte_reg};
                    mem_wr.wdata = mem_rdata | mask;
                    tw_we   = 1'b1;
                    tw_free = new_free;
                    tw_full = new_full;
                    tw_ff   = new_ff;
                    // Marking the lowest free block moves the scan forward.
                    if (!new_full && new_ff >= cur_start &&
                        fr[AW-1:KS] == (AW-KS)'({byte_reg, bit_reg}))
                    begin
                        scan_next  = BW'(byte_reg);
                        state_next = S_RSRD;
                    end
                    else
                    begin
                        r_next = '0;
                        state_next = S_SUM;
                    end
                end
                else
                begin
                    r_next = '0;
                    state_next = S_SUM;
                end
            end

            S_RSRD:
            begin
                if (scan_reg < cur_bytes)
                begin
                    mem_raddr  = {cur, scan_reg[BI-1:0]};
                    state_next = S_RSCK;
                end
                else
                begin
                    tw_we   = 1'b1;
                    tw_free = '0;
                    tw_full = 1'b1;
                    tw_ff   = '0;
                    r_next  = '0;
                    state_next = S_SUM;
                end
            end

            S_RSCK:
            begin
                if (mem_rdata != 8'hff)
                begin
                    tw_we = 1'b1;
                    tw_ff = cur_start + AW'({scan_reg[BI-1:0], {CS{1'b0}}})
                          + AW'({zpos, {KS{1'b0}}});
                    r_next = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_RSRD;
                end
            end

            S_SUM:
            begin
                if (r_reg < count_reg)
                begin
                    tsum_next = tsum_reg + rbba_pkg::BSUM_W'(cur_bytes);
                    fsum_next = fsum_reg + rbba_pkg::TOTAL_W'(cur_free);
                    r_next = r_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {7'd0, fsum_reg, tsum_reg, {CS{1'b0}},
                                      addr_reg, status_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        op_reg       <= op_next;
        off_reg      <= off_next;
        start_reg    <= start_next;
        nb_reg       <= nb_next;
        j_reg        <= j_next;
        scan_reg     <= scan_next;
        byte_reg     <= byte_next;
        bit_reg      <= bit_next;
        status_reg   <= status_next;
        addr_reg     <= addr_next;
        tsum_reg     <= tsum_next;
        fsum_reg     <= fsum_next;
        out_data_reg <= out_data_next;
        if (tw_we)
        begin
            rg_start[cur] <= tw_start;
            rg_bytes[cur] <= tw_bytes;
            rg_free[cur]  <= tw_free;
            rg_full[cur]  <= tw_full;
            rg_ff[cur]    <= tw_ff;
        end
    end

    rbba_ram u_ram (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The region count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RC'(rbba_pkg::MAX_REGIONS))
        else $error("region count beyond table size");

    // The bitmap is only written while a request is being worked.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_SUM || state_reg == S_DONE)
        |-> !mem_wr.we)
        else $error("bitmap write outside request work");

    // An accepted request always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> state_reg != S_IDLE)
        else $error("accepted beat left idle");

endmodule
